// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/rau_pkg.sv =====
// Package with shared types and constants of the rational unit.
`default_nettype none
package rau_pkg;
    localparam int DEF_WIDTH = 32;
    localparam int QDEPTH    = 2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_GT  = 3'd5,
        OP_LT  = 3'd6,
        OP_NOP = 3'd7
    } op_t;

    // Item as it passes from the front part to the back part.
    typedef struct packed {
        op_t         op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } item_t;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        cmp;
        logic        dz;
    } res_t;
endpackage
`default_nettype wire

// ===== rtl/rational_arithmetic_unit_core.sv =====
// Top level of the rational arithmetic unit.
// Usage: an input transaction on s_* carries an operation code and two fractions.
// Each produces exactly one result transaction on m_*, in order.
// A two-entry queue in the front part takes items while the back part works.
// The back part handles one item at a time: up to four products on one
// WIDTH by WIDTH multiplier, then Euclid's gcd and two divisions, all run
// one bit per cycle on a shared shift-subtract divider.
// Greater and less skip the reduction; arithmetic with a zero numerator or
// denominator skips the gcd and the divisions, and otherwise the divider runs
// Euclid's gcd and then both divisions.
// An equal compare reduces both operands, one after the other.
// The back part takes a new item only when idle, after its last result moved out.
// A result waits in the output register while m_ready is low; the back part
// finishes one more item and then holds it, and the queue keeps accepting until
// full. Reset (aresetn low, synchronous) empties the queue and drops any
// pending result.
`default_nettype none
module rational_arithmetic_unit_core #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_req_type,
    input  wire logic [31:0] s_a_num,
    input  wire logic [31:0] s_a_den,
    input  wire logic [31:0] s_b_num,
    input  wire logic [31:0] s_b_den,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_res_num,
    output logic [30:0]      m_res_den,
    output logic             m_cmp_true,
    output logic             m_div_by_zero
);
    import rau_pkg::*;

    item_t s_item, q_item;
    res_t  r_res;
    logic  q_valid, q_ready;

    assign s_item = '{op: op_t'(s_req_type), an: s_a_num, ad: s_a_den,
                      bn: s_b_num, bd: s_b_den};

    rau_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    rau_back #(.WIDTH(WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .r_valid(m_valid), .r_ready(m_ready), .r_res(r_res)
    );

    assign m_res_num     = r_res.num;
    assign m_res_den     = r_res.den;
    assign m_cmp_true    = r_res.cmp;
    assign m_div_by_zero = r_res.dz;
endmodule
`default_nettype wire

// ===== rtl/rau_front.sv =====
// Front part: takes input transactions and queues them for the back part.
`default_nettype none
module rau_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rau_pkg::item_t s_item,
    output logic                q_valid,
    input  wire logic           q_ready,
    output rau_pkg::item_t      q_item
);
    import rau_pkg::*;

    item_t      mem_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'(QDEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Queue pointer and fill count update.
    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop  ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= s_item;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rau_back.sv =====
// Back part: sequencer with shared multiplier and bit-serial divider.
`default_nettype none
module rau_back #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire rau_pkg::item_t q_item,
    output logic                r_valid,
    input  wire logic           r_ready,
    output rau_pkg::res_t       r_res
);
    import rau_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MUL  = 11'b00000000010,
        S_COMB = 11'b00000000100,
        S_RED  = 11'b00000001000,
        S_GCD  = 11'b00000010000,
        S_DIVN = 11'b00000100000,
        S_DIVD = 11'b00001000000,
        S_FIN  = 11'b00010000000,
        S_EQ2  = 11'b00100000000,
        S_CMP  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg;
    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [WIDTH-1:0] p_reg [4];
    logic [1:0]       mi_reg;
    logic [WIDTH-1:0] x_reg, y_reg;
    logic [WIDTH-1:0] g_reg, h_reg, rem_reg, quo_reg, dvd_reg, rn_reg, n0_reg;
    logic [CW-1:0]    bit_reg;
    logic             neg_reg, zd_reg, pass_reg;
    logic [WIDTH-1:0] eqn_reg;
    logic [WIDTH-1:0] eqd_reg;
    res_t             res_reg;
    res_t             out_reg;
    logic             rv_reg, rv_next;

    // Multiplier operands chosen by index.
    logic [WIDTH-1:0] ma, mb;
    always_comb begin
        ma = an_reg;
        mb = bd_reg;
        case (mi_reg)
            2'd0: begin ma = an_reg; mb = bd_reg; end
            2'd1: begin
                ma = (op_reg == OP_MUL) ? an_reg : bn_reg;
                mb = (op_reg == OP_MUL) ? bn_reg : ad_reg;
            end
            2'd2: begin
                ma = ad_reg;
                mb = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
            default: begin ma = ad_reg; mb = bn_reg; end
        endcase
    end
    logic [2*WIDTH-1:0] prod;
    assign prod = ma * mb;

    // Magnitudes of the operands going into reduction.
    logic [WIDTH-1:0] xmag, ymag;
    assign xmag = x_reg[WIDTH-1] ? -x_reg : x_reg;
    assign ymag = y_reg[WIDTH-1] ? -y_reg : y_reg;

    // One restoring division step.
    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] divisor;
    assign divisor = (state_reg == S_GCD) ? h_reg : g_reg;
    assign trial   = {rem_reg, dvd_reg[WIDTH-1]} - {1'b0, divisor};

    // Remainder after a step, and the quotient bit.
    logic [WIDTH-1:0] rem_after;
    logic             qbit;
    assign qbit      = !trial[WIDTH];
    assign rem_after = qbit ? trial[WIDTH-1:0] : {rem_reg[WIDTH-2:0], dvd_reg[WIDTH-1]};

    // Final signed numerator.
    logic [WIDTH-1:0] fin_num;
    assign fin_num = neg_reg ? -quo_reg : quo_reg;

    // Compare products after moving denominator signs onto numerators.
    logic signed [WIDTH-1:0] ln, rn;
    assign ln = signed'(p_reg[0]);
    assign rn = signed'(p_reg[1]);

    assign q_ready = (state_reg == S_IDLE);
    assign r_valid = rv_reg;
    assign r_res   = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_MUL;
            S_MUL:  if (mi_reg == 2'd3 || (op_reg == OP_GT || op_reg == OP_LT)
                        && mi_reg == 2'd1) state_next = S_COMB;
            S_COMB: state_next = (op_reg == OP_GT || op_reg == OP_LT) ? S_CMP : S_RED;
            S_RED:  state_next = (xmag == '0) ? S_FIN :
                                 (ymag == '0) ? S_FIN : S_GCD;
            S_GCD:  if (bit_reg == CW'(1) && rem_after == '0) state_next = S_DIVN;
            S_DIVN: if (bit_reg == CW'(1)) state_next = S_DIVD;
            S_DIVD: if (bit_reg == CW'(1)) state_next = S_FIN;
            S_FIN:  state_next = (op_reg == OP_EQ && !pass_reg) ? S_EQ2 :
                                 (op_reg == OP_EQ) ? S_CMP : S_OUT;
            S_EQ2:  state_next = S_RED;
            S_CMP:  state_next = S_OUT;
            S_OUT:  if (!rv_reg || r_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid: cleared when taken, set when a new result moves out.
    always_comb begin
        rv_next = rv_reg;
        if (r_valid && r_ready) rv_next = 1'b0;
        if (state_reg == S_OUT && state_next == S_IDLE) rv_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                op_reg   <= q_item.op;
                mi_reg   <= 2'd0;
                pass_reg <= 1'b0;
                res_reg  <= '{num: '0, den: 31'd1, cmp: 1'b0, dz: 1'b0};
                if ((q_item.op == OP_GT || q_item.op == OP_LT) && q_item.ad[WIDTH-1]) begin
                    an_reg <= -q_item.an[WIDTH-1:0];
                    ad_reg <= -q_item.ad[WIDTH-1:0];
                end else begin
                    an_reg <= q_item.an[WIDTH-1:0];
                    ad_reg <= q_item.ad[WIDTH-1:0];
                end
                if ((q_item.op == OP_GT || q_item.op == OP_LT) && q_item.bd[WIDTH-1]) begin
                    bn_reg <= -q_item.bn[WIDTH-1:0];
                    bd_reg <= -q_item.bd[WIDTH-1:0];
                end else begin
                    bn_reg <= q_item.bn[WIDTH-1:0];
                    bd_reg <= q_item.bd[WIDTH-1:0];
                end
            end
            S_MUL: begin
                p_reg[mi_reg] <= prod[WIDTH-1:0];
                mi_reg <= mi_reg + 2'd1;
            end
            S_COMB: begin
                unique case (op_reg)
                    OP_ADD: begin x_reg <= p_reg[0] + p_reg[1]; y_reg <= p_reg[2]; end
                    OP_SUB: begin x_reg <= p_reg[0] - p_reg[1]; y_reg <= p_reg[2]; end
                    OP_MUL: begin x_reg <= p_reg[1]; y_reg <= p_reg[2]; end
                    OP_DIV: begin x_reg <= p_reg[0]; y_reg <= p_reg[2]; end
                    OP_EQ:  begin x_reg <= an_reg; y_reg <= ad_reg; end
                    default: begin x_reg <= p_reg[0]; y_reg <= p_reg[2]; end
                endcase
            end
            S_RED: begin
                // A zero denominator keeps the numerator unreduced with its own sign.
                neg_reg <= (ymag == '0) ? x_reg[WIDTH-1] : (x_reg[WIDTH-1] ^ y_reg[WIDTH-1]);
                quo_reg <= (ymag == '0) ? xmag : '0;
                zd_reg  <= (ymag == '0);
                n0_reg  <= xmag;
                g_reg   <= xmag;
                h_reg   <= ymag;
                dvd_reg <= xmag;
                rem_reg <= '0;
                bit_reg <= CW'(WIDTH);
                rn_reg  <= ymag;
            end
            S_GCD: begin
                // Euclid: one shift-subtract step of g mod h per cycle.
                if (bit_reg == CW'(1)) begin
                    g_reg   <= h_reg;
                    rem_reg <= '0;
                    bit_reg <= CW'(WIDTH);
                    if (rem_after == '0) begin
                        dvd_reg <= n0_reg;
                        quo_reg <= '0;
                    end else begin
                        h_reg   <= rem_after;
                        dvd_reg <= h_reg;
                    end
                end else begin
                    rem_reg <= rem_after;
                    dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
                    bit_reg <= bit_reg - CW'(1);
                end
            end
            S_DIVN, S_DIVD: begin
                if (bit_reg == CW'(1)) begin
                    if (state_reg == S_DIVN) begin
                        n0_reg  <= {quo_reg[WIDTH-2:0], qbit};
                        dvd_reg <= rn_reg;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        bit_reg <= CW'(WIDTH);
                    end else begin
                        rn_reg  <= {quo_reg[WIDTH-2:0], qbit};
                        quo_reg <= n0_reg;
                        bit_reg <= bit_reg - CW'(1);
                    end
                end else begin
                    rem_reg <= rem_after;
                    dvd_reg <= {dvd_reg[WIDTH-2:0], 1'b0};
                    quo_reg <= {quo_reg[WIDTH-2:0], qbit};
                    bit_reg <= bit_reg - CW'(1);
                end
            end
            S_FIN: begin
                if (op_reg == OP_EQ) begin
                    // A zero numerator always reduces to 0/1.
                    eqn_reg  <= (n0_reg == '0) ? '0 : fin_num;
                    eqd_reg  <= (n0_reg == '0) ? WIDTH'(1) : zd_reg ? '0 : rn_reg;
                    pass_reg <= 1'b1;
                    res_reg  <= '{num: '0, den: 31'd1, cmp: 1'b0, dz: 1'b0};
                end else if (op_reg == OP_DIV && bn_reg == '0) begin
                    res_reg <= '{num: '0, den: 31'd1, cmp: 1'b0, dz: 1'b1};
                end else if (op_reg == OP_NOP || n0_reg == '0) begin
                    res_reg <= '{num: '0, den: 31'd1, cmp: 1'b0, dz: 1'b0};
                end else begin
                    res_reg <= '{num: 32'(signed'(fin_num)),
                                 den: zd_reg ? 31'd0 : 31'(rn_reg),
                                 cmp: 1'b0, dz: 1'b0};
                end
            end
            S_EQ2: begin
                x_reg <= bn_reg;
                y_reg <= bd_reg;
                p_reg[3] <= eqn_reg;
                p_reg[2] <= eqd_reg;
            end
            S_CMP: begin
                if (op_reg == OP_EQ)
                    res_reg.cmp <= (p_reg[3] == eqn_reg) && (p_reg[2] == eqd_reg);
                else
                    res_reg.cmp <= (op_reg == OP_GT) ? (ln > rn) : (ln < rn);
            end
            S_OUT: begin
                // Move the result out once the output register is free.
                if (state_next == S_IDLE) out_reg <= res_reg;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/rau_checker.sv =====
// Port checker for the rational arithmetic unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rau_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [30:0] m_res_den,
    input wire logic        m_cmp_true,
    input wire logic        m_div_by_zero,
    input wire logic [31:0] m_res_num
);
    `CHK_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_res_num))
    `CHK_IMPL(a_flags, aclk, aresetn, m_valid, !(m_cmp_true && m_div_by_zero))
    `CHK_IMPL(a_dz, aclk, aresetn, m_valid && m_div_by_zero, m_res_num == 32'd0 && m_res_den == 31'd1)
    `CHK_IMPL(a_cmp, aclk, aresetn, m_valid && m_cmp_true, m_res_num == 32'd0 && m_res_den == 31'd1)
endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_res_den(m_res_den), .m_cmp_true(m_cmp_true),
    .m_div_by_zero(m_div_by_zero), .m_res_num(m_res_num)
);
`default_nettype wire
